// ----- design/chc8_pkg.sv -----
// ----------------------------------------------------------------------------
// chc8_pkg: shared types and constants for the ChaCha8 byte stream XOR
// Item and configuration types, register indexes, round constants.
// ----------------------------------------------------------------------------
package chc8_pkg;

   localparam int DOUBLE_ROUNDS_DEF = 4;
   localparam int QUEUE_DEPTH_DEF   = 4;

   localparam int CSR_IDX_W = 3;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD0   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD1   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD2   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD3   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NONCE_VALUE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_IS_256  = 3'd5;

   // "expand 32-byte k" / "expand 16-byte k"
   localparam logic [31:0] SIGMA0 = 32'h61707865;
   localparam logic [31:0] SIGMA1 = 32'h3320646e;
   localparam logic [31:0] SIGMA2 = 32'h79622d32;
   localparam logic [31:0] SIGMA3 = 32'h6b206574;
   localparam logic [31:0] TAU1   = 32'h3120646e;
   localparam logic [31:0] TAU2   = 32'h79622d36;

   typedef struct packed {
      logic [7:0] data;
      logic       restart;
   } item_type;

   typedef struct packed {
      logic [63:0] key_word0;
      logic [63:0] key_word1;
      logic [63:0] key_word2;
      logic [63:0] key_word3;
      logic [63:0] nonce_value;
      logic        key_is_256;
   } cfg_type;

   typedef enum logic [1:0] {
      GEN_IDLE,
      GEN_ROUND,
      GEN_FINAL
   } gen_state_type;

endpackage

// ----- design/chc8_front.sv -----
// ----------------------------------------------------------------------------
// chc8_front: request intake and item queue
// Accepts bytes, tags each with its restart flag and queues them for the back.
// ----------------------------------------------------------------------------
module chc8_front import chc8_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_in,
   input  logic       req_restart,
   output logic       head_valid,
   output item_type   head_item,
   input  logic       head_pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   item_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;

   assign req_ready  = (count_ff != CNT_FULL);
   assign push       = req_valid && req_ready;
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (head_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !head_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && head_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{data: req_data_in, restart: req_restart};
      end
   end

endmodule

// ----- design/chc8_qr_step.sv -----
// ----------------------------------------------------------------------------
// chc8_qr_step: one add-xor-rotate step of a ChaCha quarter round
// Step 0/2 update a and d, step 1/3 update c and b.
// ----------------------------------------------------------------------------
module chc8_qr_step import chc8_pkg::*; (
   input  logic [1:0]  step,
   input  logic [31:0] a_i,
   input  logic [31:0] b_i,
   input  logic [31:0] c_i,
   input  logic [31:0] d_i,
   output logic [31:0] a_o,
   output logic [31:0] b_o,
   output logic [31:0] c_o,
   output logic [31:0] d_o
);

   logic [31:0] sum_ad, sum_cd, mix_d, mix_b;

   assign sum_ad = a_i + b_i;
   assign sum_cd = c_i + d_i;
   assign mix_d  = d_i ^ sum_ad;
   assign mix_b  = b_i ^ sum_cd;

   always_comb begin
      a_o = a_i;
      b_o = b_i;
      c_o = c_i;
      d_o = d_i;
      case (step)
         2'd0: begin
            a_o = sum_ad;
            d_o = {mix_d[15:0], mix_d[31:16]};
         end
         2'd1: begin
            c_o = sum_cd;
            b_o = {mix_b[19:0], mix_b[31:20]};
         end
         2'd2: begin
            a_o = sum_ad;
            d_o = {mix_d[23:0], mix_d[31:24]};
         end
         2'd3: begin
            c_o = sum_cd;
            b_o = {mix_b[24:0], mix_b[31:25]};
         end
         default: begin
            a_o = a_i;
         end
      endcase
   end

endmodule

// ----- design/chc8_back.sv -----
// ----------------------------------------------------------------------------
// chc8_back: keystream engine and output stage
// Builds 64-byte keystream blocks with four parallel quarter-round lanes and
// XORs queued bytes with them into a registered result.
// ----------------------------------------------------------------------------
module chc8_back import chc8_pkg::*; #(
   parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       head_valid,
   input  item_type   head_item,
   output logic       head_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_data_out
);

   localparam int RND_W = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;
   localparam logic [RND_W-1:0] RND_LAST = RND_W'(DOUBLE_ROUNDS - 1);

   gen_state_type state_ff, state_in;

   logic [31:0] x_ff  [16];
   logic [31:0] x_in  [16];
   logic [31:0] ks_ff [16];
   logic [31:0] init_w [16];

   logic [63:0]      counter_ff, counter_in;
   logic [5:0]       pos_ff, pos_in;
   logic             ready_ff, ready_in;
   logic             fresh_ff, fresh_in;   // head's restart already served
   logic [1:0]       step_ff, step_in;
   logic             diag_ff, diag_in;
   logic [RND_W-1:0] round_ff, round_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_data_ff, rsp_data_in;

   logic        restart_eff, ks_ok, out_free, start_gen, ks_write;
   logic [63:0] gen_ctr;
   logic [31:0] ks_word;
   logic [7:0]  ks_byte;

   logic [3:0]  ia [4];
   logic [3:0]  ib [4];
   logic [3:0]  ic [4];
   logic [3:0]  id [4];
   logic [31:0] qa [4];
   logic [31:0] qb [4];
   logic [31:0] qc [4];
   logic [31:0] qd [4];

   assign restart_eff = head_item.restart && !fresh_ff;
   assign ks_ok       = ready_ff && !restart_eff;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign start_gen   = (state_ff == GEN_IDLE) && head_valid && !ks_ok;
   assign head_pop    = (state_ff == GEN_IDLE) && head_valid && ks_ok && out_free;
   assign ks_write    = (state_ff == GEN_FINAL);

   // counter seen by the input state; a restart starts from block zero
   assign gen_ctr = (start_gen && restart_eff) ? 64'd0 : counter_ff;

   always_comb begin
      logic [63:0] kw2, kw3;
      kw2 = cfg.key_is_256 ? cfg.key_word2 : cfg.key_word0;
      kw3 = cfg.key_is_256 ? cfg.key_word3 : cfg.key_word1;
      init_w[0]  = SIGMA0;
      init_w[1]  = cfg.key_is_256 ? SIGMA1 : TAU1;
      init_w[2]  = cfg.key_is_256 ? SIGMA2 : TAU2;
      init_w[3]  = SIGMA3;
      init_w[4]  = cfg.key_word0[31:0];
      init_w[5]  = cfg.key_word0[63:32];
      init_w[6]  = cfg.key_word1[31:0];
      init_w[7]  = cfg.key_word1[63:32];
      init_w[8]  = kw2[31:0];
      init_w[9]  = kw2[63:32];
      init_w[10] = kw3[31:0];
      init_w[11] = kw3[63:32];
      init_w[12] = gen_ctr[31:0];
      init_w[13] = gen_ctr[63:32];
      init_w[14] = cfg.nonce_value[31:0];
      init_w[15] = cfg.nonce_value[63:32];
   end

   // four lanes: columns on even half rounds, diagonals on odd ones
   for (genvar l = 0; l < 4; l++) begin : g_lane
      localparam logic [3:0] COL_B = 4'(4 + l);
      localparam logic [3:0] COL_C = 4'(8 + l);
      localparam logic [3:0] COL_D = 4'(12 + l);
      localparam logic [3:0] DIA_B = 4'(4 + ((l + 1) % 4));
      localparam logic [3:0] DIA_C = 4'(8 + ((l + 2) % 4));
      localparam logic [3:0] DIA_D = 4'(12 + ((l + 3) % 4));

      assign ia[l] = 4'(l);
      assign ib[l] = diag_ff ? DIA_B : COL_B;
      assign ic[l] = diag_ff ? DIA_C : COL_C;
      assign id[l] = diag_ff ? DIA_D : COL_D;

      chc8_qr_step u_step (
         .step (step_ff),
         .a_i  (x_ff[ia[l]]),
         .b_i  (x_ff[ib[l]]),
         .c_i  (x_ff[ic[l]]),
         .d_i  (x_ff[id[l]]),
         .a_o  (qa[l]),
         .b_o  (qb[l]),
         .c_o  (qc[l]),
         .d_o  (qd[l])
      );
   end

   assign ks_word = ks_ff[pos_ff[5:2]];

   always_comb begin
      case (pos_ff[1:0])
         2'd0:    ks_byte = ks_word[7:0];
         2'd1:    ks_byte = ks_word[15:8];
         2'd2:    ks_byte = ks_word[23:16];
         2'd3:    ks_byte = ks_word[31:24];
         default: ks_byte = ks_word[7:0];
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      counter_in   = counter_ff;
      pos_in       = pos_ff;
      ready_in     = ready_ff;
      fresh_in     = fresh_ff;
      step_in      = step_ff;
      diag_in      = diag_ff;
      round_in     = round_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         GEN_IDLE: begin
            if (start_gen) begin
               x_in     = init_w;
               ready_in = 1'b0;
               fresh_in = 1'b1;
               step_in  = '0;
               diag_in  = 1'b0;
               round_in = '0;
               state_in = GEN_ROUND;
               if (restart_eff) begin
                  counter_in = '0;
                  pos_in     = '0;
               end
            end else if (head_pop) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = head_item.data ^ ks_byte;
               pos_in       = pos_ff + 1'b1;
               fresh_in     = 1'b0;
               if (pos_ff == 6'd63) begin
                  counter_in = counter_ff + 64'd1;
                  ready_in   = 1'b0;
               end
            end
         end
         GEN_ROUND: begin
            for (int l = 0; l < 4; l++) begin
               x_in[ia[l]] = qa[l];
               x_in[ib[l]] = qb[l];
               x_in[ic[l]] = qc[l];
               x_in[id[l]] = qd[l];
            end
            step_in = step_ff + 1'b1;
            if (step_ff == 2'd3) begin
               diag_in = !diag_ff;
               if (diag_ff) begin
                  round_in = round_ff + 1'b1;
                  if (round_ff == RND_LAST) begin
                     state_in = GEN_FINAL;
                  end
               end
            end
         end
         GEN_FINAL: begin
            ready_in = 1'b1;
            state_in = GEN_IDLE;
         end
         default: begin
            state_in = GEN_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= GEN_IDLE;
         counter_ff   <= '0;
         pos_ff       <= '0;
         ready_ff     <= 1'b0;
         fresh_ff     <= 1'b0;
         step_ff      <= '0;
         diag_ff      <= 1'b0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         counter_ff   <= counter_in;
         pos_ff       <= pos_in;
         ready_ff     <= ready_in;
         fresh_ff     <= fresh_in;
         step_ff      <= step_in;
         diag_ff      <= diag_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      rsp_data_ff <= rsp_data_in;
      if (ks_write) begin
         for (int i = 0; i < 16; i++) begin
            ks_ff[i] <= x_ff[i] + init_w[i];
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;

endmodule

// ----- design/chacha8_stream_xor.sv -----
// ----------------------------------------------------------------------------
// chacha8_stream_xor: ChaCha8 byte stream XOR (64-bit counter, 64-bit nonce)
// Each byte is XORed with the next keystream byte; restart begins a message.
// ----------------------------------------------------------------------------
//
//   channel  signals                                   direction  role
//   req      req_valid/ready, req_data_in, req_restart  in         byte + restart
//   rsp      rsp_valid/ready, rsp_data_out              out        byte ^ keystream
//   csr      csr_valid/ready, csr_index, csr_data       in         register write
//
// Within a keystream block the back end retires one byte per cycle while the
// result register is not stalled. A new block (first byte, every 64 bytes,
// or a restart) is built in the round engine by the four quarter-round lanes,
// which do one add/xor/rotate step per cycle. Reset is synchronous; there is
// no clearing pass. The request queue keeps taking bytes until it is full
// while the engine works or the result register is stalled.
// csr_ready is always high; indexes past the register list are ignored.
// ----------------------------------------------------------------------------
module chacha8_stream_xor import chc8_pkg::*; #(
   parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF,
   parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_data_in,
   input  logic                 req_restart,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_data_out,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_data
);

   cfg_type  cfg_ff, cfg_in;
   logic     head_valid;
   item_type head_item;
   logic     head_pop;

   // register file: always ready, writes land the next cycle
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_KEY_WORD0:   cfg_in.key_word0   = csr_data;
            CSR_KEY_WORD1:   cfg_in.key_word1   = csr_data;
            CSR_KEY_WORD2:   cfg_in.key_word2   = csr_data;
            CSR_KEY_WORD3:   cfg_in.key_word3   = csr_data;
            CSR_NONCE_VALUE: cfg_in.nonce_value = csr_data;
            CSR_KEY_IS_256:  cfg_in.key_is_256  = csr_data[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // 256-bit key mode after reset
         cfg_ff <= '{key_is_256: 1'b1, default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: intake queue, decouples the link from block generation
   chc8_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data_in (req_data_in),
      .req_restart (req_restart),
      .head_valid  (head_valid),
      .head_item   (head_item),
      .head_pop    (head_pop)
   );

   // back: round engine, keystream block, output register
   chc8_back #(
      .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .head_valid   (head_valid),
      .head_item    (head_item),
      .head_pop     (head_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data_out (rsp_data_out)
   );

endmodule

// ----- design/chc8_checker.sv -----
// ----------------------------------------------------------------------------
// chc8_checker: port-level checks for the ChaCha8 stream XOR
// Tracks items in flight from the handshakes and checks stalls and bounds.
// ----------------------------------------------------------------------------
module chc8_checker import chc8_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_data_out,
   input logic       csr_ready
);

   localparam int OUT_W = $clog2(QUEUE_DEPTH + 3);
   localparam logic [OUT_W-1:0] OUT_MAX = OUT_W'(QUEUE_DEPTH + 1);

   logic [OUT_W-1:0] inflight_ff, inflight_in;
   logic             req_acc, rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_comb begin
      inflight_in = inflight_ff;
      if (req_acc && !rsp_acc) begin
         inflight_in = inflight_ff + 1'b1;
      end else if (!req_acc && rsp_acc) begin
         inflight_in = inflight_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_out))
      else $error("stalled result changed");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> inflight_ff != '0)
      else $error("result without an accepted item");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= OUT_MAX)
      else $error("more items in flight than queue and output hold");

   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      req_acc |-> csr_ready)
      else $error("register port blocked");

endmodule

bind chacha8_stream_xor chc8_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_chc8_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_data_out (rsp_data_out),
   .csr_ready    (csr_ready)
);

// ----- tb/chacha8_xor_checker.sv -----
// ----------------------------------------------------------------------------
// chacha8_xor_checker: keystream predictor and result scoreboard
// Watches the req, rsp and csr channels of the ChaCha8 byte stream XOR,
// keeps its own cipher state, and compares each returned byte in order.
// ----------------------------------------------------------------------------
module chacha8_xor_checker import chc8_pkg::*; #(
   parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [7:0]           req_data_in,
   input  logic                 req_restart,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [7:0]           rsp_data_out,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_data,
   input  logic                 drain_done,
   output int                   fail_count,
   output int                   bytes_pending,
   output int                   bytes_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   cfg_type     cipher_cfg;
   logic [31:0] ks_words [16];
   logic [63:0] blk_ctr;
   logic [5:0]  byte_pos;
   logic        have_block;
   logic [7:0]  expected_bytes [$];
   bit          leftover_seen;

   task automatic report_mismatch(input string msg);
      fail_count++;
      $display("%0t ns  checker: %s", $time, msg);
   endtask

   function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
      return (v << s) | (v >> (32 - s));
   endfunction

   function automatic logic [127:0] qround(input logic [31:0] a, b, c, d);
      a = a + b; d = rotl(d ^ a, 16);
      c = c + d; b = rotl(b ^ c, 12);
      a = a + b; d = rotl(d ^ a, 8);
      c = c + d; b = rotl(b ^ c, 7);
      return {a, b, c, d};
   endfunction

   // One keystream block from the current key, nonce and counter.
   function automatic void refill_keystream();
      logic [31:0] init [16];
      logic [31:0] x [16];
      logic [63:0] kw [4];
      // four column lanes, then four diagonal lanes
      int lanes [8][4] = '{'{0, 4, 8, 12}, '{1, 5, 9, 13}, '{2, 6, 10, 14},
                           '{3, 7, 11, 15}, '{0, 5, 10, 15}, '{1, 6, 11, 12},
                           '{2, 7, 8, 13}, '{3, 4, 9, 14}};
      kw[0] = cipher_cfg.key_word0;
      kw[1] = cipher_cfg.key_word1;
      if (cipher_cfg.key_is_256) begin
         kw[2] = cipher_cfg.key_word2;
         kw[3] = cipher_cfg.key_word3;
         init[0] = SIGMA0; init[1] = SIGMA1; init[2] = SIGMA2; init[3] = SIGMA3;
      end else begin
         // 128-bit key is used twice
         kw[2] = cipher_cfg.key_word0;
         kw[3] = cipher_cfg.key_word1;
         init[0] = SIGMA0; init[1] = TAU1; init[2] = TAU2; init[3] = SIGMA3;
      end
      for (int i = 0; i < 4; i++) begin
         init[4 + 2 * i] = kw[i][31:0];
         init[5 + 2 * i] = kw[i][63:32];
      end
      init[12] = blk_ctr[31:0];
      init[13] = blk_ctr[63:32];
      init[14] = cipher_cfg.nonce_value[31:0];
      init[15] = cipher_cfg.nonce_value[63:32];
      x = init;
      for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
         for (int q = 0; q < 8; q++) begin
            {x[lanes[q][0]], x[lanes[q][1]], x[lanes[q][2]], x[lanes[q][3]]} =
               qround(x[lanes[q][0]], x[lanes[q][1]], x[lanes[q][2]], x[lanes[q][3]]);
         end
      end
      for (int i = 0; i < 16; i++) begin
         ks_words[i] = x[i] + init[i];
      end
      have_block = 1'b1;
   endfunction

   function automatic logic [7:0] next_cipher_byte(input logic [7:0] data,
                                                   input logic restart);
      logic [7:0] ks;
      if (restart) begin
         blk_ctr    = '0;
         byte_pos   = '0;
         have_block = 1'b0;
      end
      if (!have_block) refill_keystream();
      // little-endian byte order within each word
      ks = ks_words[byte_pos[5:2]][8 * byte_pos[1:0] +: 8];
      byte_pos = byte_pos + 6'd1;
      if (byte_pos == 6'd0) begin
         blk_ctr    = blk_ctr + 64'd1;
         have_block = 1'b0;
      end
      return data ^ ks;
   endfunction

   always @(posedge clock) begin : watch
      logic [7:0] want;
      if (reset) begin
         cipher_cfg            = '0;
         cipher_cfg.key_is_256 = 1'b1;
         blk_ctr               = '0;
         byte_pos              = '0;
         have_block            = 1'b0;
         expected_bytes.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_KEY_WORD0:   cipher_cfg.key_word0   = csr_data;
               CSR_KEY_WORD1:   cipher_cfg.key_word1   = csr_data;
               CSR_KEY_WORD2:   cipher_cfg.key_word2   = csr_data;
               CSR_KEY_WORD3:   cipher_cfg.key_word3   = csr_data;
               CSR_NONCE_VALUE: cipher_cfg.nonce_value = csr_data;
               CSR_KEY_IS_256:  cipher_cfg.key_is_256  = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            expected_bytes.push_back(next_cipher_byte(req_data_in, req_restart));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("unexpected result byte %02h", rsp_data_out));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_data_out !== want) begin
                  report_mismatch($sformatf("data_out %02h, want %02h (result %0d)",
                                            rsp_data_out, want, bytes_checked));
               end
               bytes_checked++;
            end
         end
         if (drain_done && !leftover_seen) begin
            leftover_seen = 1'b1;
            if (expected_bytes.size() != 0) begin
               report_mismatch($sformatf("%0d result bytes never returned",
                                         expected_bytes.size()));
            end
         end
      end
      bytes_pending <= expected_bytes.size();
   end

endmodule

// ----- tb/tb_chacha8_stream_xor.sv -----
// ----------------------------------------------------------------------------
// tb_chacha8_stream_xor: stimulus and verdict for the ChaCha8 byte stream XOR
// Drives byte messages and register settings through the valid/ready ports
// with random idle bursts; a separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_chacha8_stream_xor;
   timeunit 1ns;
   timeprecision 1ps;
   import chc8_pkg::*;

   // indexes past the register list, which the block must ignore
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE7 = 3'd7;

   // settings kinds for pick_settings
   localparam int KEYS_RANDOM = 0;
   localparam int KEYS_ZERO   = 1;
   localparam int KEYS_ONES   = 2;

   localparam int PHASE_BYTES    = 170;
   localparam int LONG_HOLD      = 150;   // receiver hold-off, in cycles
   localparam int TAIL_CYCLES    = 40;    // longer than one block build
   localparam int WATCHDOG_LIMIT = 2000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_data_in = '0;
   logic                 req_restart = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [7:0]           rsp_data_out;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0]          csr_data = '0;
   logic                 drain_done = 1'b0;

   int fail_count;
   int bytes_pending;
   int bytes_checked;

   // idling controls, shared between the stimulus and the receiver
   bit send_gaps;
   bit take_gaps;
   bit hold_request;

   int bytes_sent;
   int restarts_sent;
   int settings_used;

   chacha8_stream_xor dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data_in  (req_data_in),
      .req_restart  (req_restart),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data_out (rsp_data_out),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   chacha8_xor_checker chk (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_in   (req_data_in),
      .req_restart   (req_restart),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data_out  (rsp_data_out),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .drain_done    (drain_done),
      .fail_count    (fail_count),
      .bytes_pending (bytes_pending),
      .bytes_checked (bytes_checked)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // --------------------------------------------------------------------------
   // Receiver: random ready bursts, plus one long hold-off on request. The
   // hold is counted here, so the sender keeps pushing until the block's
   // request queue fills and req_ready drops.
   // --------------------------------------------------------------------------
   initial begin : receiver
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (take_gaps && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // --------------------------------------------------------------------------
   // Watchdog: ends the run after a long stretch with no handshake at all.
   // --------------------------------------------------------------------------
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("[chacha8_stream_xor] ERROR");
      $finish;
   end

   // Offer one byte and wait for it to be taken. Valid stays high on return,
   // so back-to-back bytes go out without a bubble unless send_gaps adds idle gaps.
   task automatic send_byte(input logic [7:0] data, input logic restart);
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_data_in <= data;
      req_restart <= restart;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      if (restart) restarts_sent++;
   endtask

   // Drop valid and wait until every byte offered so far has come back.
   // The first edge lets the checker's count catch the last accepted item.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (bytes_pending != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Full register set, preceded by a write to a spare index that must not
   // disturb anything.
   task automatic write_settings(input cfg_type c);
      write_reg(($urandom_range(0, 1) != 0) ? CSR_SPARE6 : CSR_SPARE7,
                {$urandom, $urandom});
      write_reg(CSR_KEY_WORD0, c.key_word0);
      write_reg(CSR_KEY_WORD1, c.key_word1);
      write_reg(CSR_KEY_WORD2, c.key_word2);
      write_reg(CSR_KEY_WORD3, c.key_word3);
      write_reg(CSR_NONCE_VALUE, c.nonce_value);
      // upper bits of the flag word are don't-care
      write_reg(CSR_KEY_IS_256, {$urandom, 31'($urandom), c.key_is_256});
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   function automatic cfg_type pick_settings(input int kind, input logic wide_key);
      cfg_type c;
      case (kind)
         KEYS_ZERO: c = '0;
         KEYS_ONES: c = '1;
         default: begin
            c.key_word0   = {$urandom, $urandom};
            c.key_word1   = {$urandom, $urandom};
            c.key_word2   = {$urandom, $urandom};
            c.key_word3   = {$urandom, $urandom};
            c.nonce_value = {$urandom, $urandom};
         end
      endcase
      c.key_is_256 = wide_key;
      return c;
   endfunction

   // --------------------------------------------------------------------------
   // Random stream: mostly well-formed messages (restart on the first byte),
   // a quarter of them long enough to cross one or more 64-byte blocks, and
   // some noise bursts with restart set at random. If carry_on is set, the
   // first message continues the previous stream, so a key change made while
   // a block was held only shows up at the next block.
   // --------------------------------------------------------------------------
   task automatic run_stream(input int n_bytes, input bit carry_on);
      int sent;
      int len;
      bit first;
      sent  = 0;
      first = carry_on;
      while (sent < n_bytes) begin
         if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(1, 8);
            repeat (len) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end else begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(65, 200)
                                              : $urandom_range(1, 64);
            for (int i = 0; i < len; i++) begin
               send_byte(8'($urandom_range(0, 255)), (i == 0) && !first);
            end
         end
         first = 1'b0;
         sent += len;
      end
   endtask

   initial begin : stimulus
      send_gaps    = 1'b0;
      take_gaps    = 1'b0;
      hold_request = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // ---- directed ----
      // reset settings (zero key, 256-bit); no restart on the first bytes,
      // so the stream must start at block 0, position 0 on its own
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h5a, 1'b0);
      // restart mid-block discards the held block
      send_byte(8'ha5, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      wait_idle();

      // all-ones key and nonce, 128-bit key. Written mid-block: the next
      // bytes still use the block already built.
      write_settings(pick_settings(KEYS_ONES, 1'b0));
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b1);
      send_byte(8'hff, 1'b0);
      send_byte(8'h7f, 1'b0);
      wait_idle();

      // same extremes with the 256-bit key
      write_settings(pick_settings(KEYS_ONES, 1'b1));
      send_byte(8'hff, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hc3, 1'b0);
      wait_idle();

      // ---- random phases ----
      // 1: random 256-bit key, continuing the stream, gaps on both sides
      send_gaps = 1'b1;
      take_gaps = 1'b1;
      write_settings(pick_settings(KEYS_RANDOM, 1'b1));
      run_stream(PHASE_BYTES, 1'b1);
      wait_idle();

      // 2: random 128-bit key; receiver holds off while the sender pushes
      // without pause, so the block has to back-pressure its input
      send_gaps = 1'b0;
      write_settings(pick_settings(KEYS_RANDOM, 1'b0));
      hold_request = 1'b1;
      run_stream(PHASE_BYTES, 1'b0);
      wait_idle();

      // 3: zero key and nonce, 128-bit key
      send_gaps = 1'b1;
      write_settings(pick_settings(KEYS_ZERO, 1'b0));
      run_stream(PHASE_BYTES, 1'b1);
      wait_idle();

      // 4: random 256-bit key, sender gaps only
      take_gaps = 1'b0;
      write_settings(pick_settings(KEYS_RANDOM, 1'b1));
      run_stream(PHASE_BYTES, 1'b0);
      wait_idle();

      // 5: last part runs at full rate with no idling
      send_gaps = 1'b0;
      write_settings(pick_settings(KEYS_RANDOM, 1'($urandom_range(0, 1))));
      run_stream(PHASE_BYTES, 1'b1);
      wait_idle();

      // let any trailing activity settle, then flag leftovers
      repeat (TAIL_CYCLES) @(posedge clock);
      drain_done <= 1'b1;
      repeat (2) @(posedge clock);

      $display("run: %0d bytes sent (%0d with restart), %0d register settings",
               bytes_sent, restarts_sent, settings_used);
      $display("run: %0d result bytes checked, %0d mismatches", bytes_checked, fail_count);
      if (fail_count == 0) begin
         $display("[chacha8_stream_xor] OK");
      end else begin
         $display("[chacha8_stream_xor] ERROR");
      end
      $finish;
   end

endmodule
